@@ rtl/lahs_pkg.sv @@
// Shared types and constants of the lux average headlight switch.
package lahs_pkg;

  localparam int RAW_W       = 16;
  localparam int MANT_W      = 12;
  localparam int EXP_W       = 4;
  localparam int LUX_W       = 16;
  localparam int SCALED_W    = 27;
  localparam int NIGHT_W     = 23;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int OUT_TDATA_W = 40;

  // floor(x / 100) as (x * ceil(2^30 / 100)) >> 30, exact for x below 2^23
  localparam logic [RECIP_W-1:0]  RECIP_100   = 24'd10737419;
  localparam logic [NIGHT_W-1:0]  LUX_SCALE   = 23'd100;
  // smallest scaled reading whose lux no longer fits in 16 bits
  localparam logic [SCALED_W-1:0] LUX_SAT_LIM = 27'd6553600;
  localparam logic [LUX_W-1:0]    LUX_MAX     = 16'hFFFF;
  localparam logic [LUX_W-1:0]    THR_RESET   = 16'd40;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic             night;
  } lux_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } win_ctl_t;

endpackage

@@ rtl/lahs_lux_conv.sv @@
// Sensor word to whole-lux conversion with saturation and the night test.
module lahs_lux_conv (
  input  logic [lahs_pkg::RAW_W-1:0]   raw,
  input  logic [lahs_pkg::NIGHT_W-1:0] thr100,
  output lahs_pkg::lux_res_t           res
);
  import lahs_pkg::*;

  logic [MANT_W-1:0]          mant;
  logic [EXP_W-1:0]           expo;
  logic [SCALED_W-1:0]        scaled;
  logic [NIGHT_W+RECIP_W-1:0] prod;
  logic [LUX_W-1:0]           quot;

  assign mant   = raw[MANT_W-1:0];
  assign expo   = raw[RAW_W-1:MANT_W];
  assign scaled = {{(SCALED_W-MANT_W){1'b0}}, mant} << expo;

  // only needed below the saturation limit, which keeps the operand at 23 bits
  assign prod = scaled[NIGHT_W-1:0] * RECIP_100;
  assign quot = prod[RECIP_SHIFT +: LUX_W];

  always_comb begin
    res.lux   = (scaled >= LUX_SAT_LIM) ? LUX_MAX : quot;
    res.night = scaled < {{(SCALED_W-NIGHT_W){1'b0}}, thr100};
  end

endmodule

@@ rtl/lahs_window.sv @@
// Ring-buffer window with running sum, write slot and window-full flag.
module lahs_window #(
  parameter int WINDOW_LEN = 16,
  parameter int SUM_W      = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lahs_pkg::win_ctl_t         ctl,
  input  logic [lahs_pkg::LUX_W-1:0] wr_lux,
  output logic [SUM_W-1:0]           new_sum,
  output logic                       avg_ok,
  output logic                       full
);
  import lahs_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  logic [LUX_W-1:0]      mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] ent_vld_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [SLOT_W-1:0]     slot_nxt;
  logic [SLOT_W-1:0]     rd_slot_r;
  logic [LUX_W-1:0]      mem_q_r;
  logic                  ent_q_r;
  logic                  avg_ok_r;
  logic                  full_r;
  logic [SUM_W-1:0]      sum_r;
  logic [LUX_W-1:0]      old_lux;

  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // evicted value; a slot never written since reset reads as zero
  assign old_lux = ent_q_r ? mem_q_r : '0;
  assign new_sum = sum_r - SUM_W'(old_lux) + SUM_W'(wr_lux);
  assign avg_ok  = avg_ok_r;
  assign full    = full_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[rd_slot_r] <= wr_lux;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_slot_r <= slot_r;
      ent_q_r   <= ent_vld_r[slot_r];
      avg_ok_r  <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      slot_r    <= '0;
      full_r    <= 1'b0;
      sum_r     <= '0;
    end else begin
      if (ctl.rd_en) begin
        slot_r <= slot_nxt;
        full_r <= full_r | (slot_nxt == LAST_SLOT);
      end
      if (ctl.wr_en) begin
        ent_vld_r[rd_slot_r] <= 1'b1;
        sum_r                <= new_sum;
      end
    end
  end

endmodule

@@ rtl/lahs_avg_div.sv @@
// Window sum divided by the window length, by reciprocal multiplication.
module lahs_avg_div #(
  parameter int WINDOW_LEN = 16,
  parameter int SUM_W      = 20
) (
  input  logic [SUM_W-1:0]           sum,
  output logic [lahs_pkg::LUX_W-1:0] avg
);
  import lahs_pkg::*;

  // exact floor for every sum below 2^SUM_W: rounding error stays under 1/WINDOW_LEN
  localparam int SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int M_W   = SUM_W + 1;
  localparam longint unsigned ONE_L   = 1;
  localparam longint unsigned RECIP_L =
    ((ONE_L << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

  logic [SUM_W+M_W-1:0] prod;

  assign prod = sum * RECIP;
  assign avg  = prod[SHIFT +: LUX_W];

endmodule

@@ rtl/lux_average_headlight_switch.sv @@
// Top level of the lux average headlight switch.
// Each accepted item is one light-sensor result word (exponent in bits 15..12,
// mantissa in bits 11..0). The block turns it into whole lux, floor of
// (mantissa << exponent) / 100 saturated at 65535, keeps a ring window of the
// last WINDOW_LEN lux values with a running sum, and from the WINDOW_LEN-th item
// after reset on reports the floored window average (zero before that, with
// average_valid low). The headlight turns off when the exact window average
// exceeds the night threshold and turns on when the exact unsaturated reading
// of the item lies below it; light_changed flags each switch. One item is
// accepted every cycle while the output is not stalled; each item passes the
// pipeline input register and then the conversion, window update and divide
// stages, each closed by a register, before its result reaches the output. The
// whole pipeline holds while a result waits at the output.
// The window needs no clearing pass: a valid bit per slot makes an unwritten
// slot read as zero straight after reset. The night threshold resets to 40; the
// user must write it through the cfg port only while no item is in flight, which
// the block itself does not enforce. It applies to the next item accepted.
module lux_average_headlight_switch #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: raw_reading[15:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lahs_pkg::RAW_W-1:0]       in_tdata,
  // out_tdata: lux_value[15:0], average_lux[31:16], average_valid[32],
  //            headlight_on[33], light_changed[34], zero fill [39:35]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lahs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // cfg_data: night_threshold[15:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lahs_pkg::LUX_W-1:0]       cfg_data
);
  import lahs_pkg::*;

  localparam int SUM_W = LUX_W + $clog2(WINDOW_LEN);

  logic               adv;

  // threshold in the two scales the lamp tests compare against
  logic [NIGHT_W-1:0] thr100_r;
  logic [SUM_W-1:0]   thrn_r;

  logic               s1_vld_r;
  logic [RAW_W-1:0]   s1_raw_r;
  lux_res_t           conv;

  logic               s2_vld_r;
  logic [LUX_W-1:0]   s2_lux_r;
  logic               s2_night_r;
  win_ctl_t           win_ctl;
  logic [SUM_W-1:0]   win_sum;
  logic               win_avg_ok;
  logic               win_full;

  logic               lamp_r;
  logic               lamp_nxt;
  logic               turn_off;
  logic               turn_on;

  logic               s3_vld_r;
  logic [LUX_W-1:0]   s3_lux_r;
  logic [SUM_W-1:0]   s3_sum_r;
  logic               s3_avg_ok_r;
  logic               s3_lamp_r;
  logic               s3_chg_r;
  logic [LUX_W-1:0]   avg;

  logic               out_vld_r;
  logic [LUX_W-1:0]   out_lux_r;
  logic [LUX_W-1:0]   out_avg_r;
  logic               out_avg_ok_r;
  logic               out_lamp_r;
  logic               out_chg_r;

  // advance every stage together unless a result is stuck at the output
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr100_r <= NIGHT_W'(THR_RESET) * LUX_SCALE;
      thrn_r   <= SUM_W'(THR_RESET) * SUM_W'(WINDOW_LEN);
    end else if (cfg_valid) begin
      thr100_r <= NIGHT_W'(cfg_data) * LUX_SCALE;
      thrn_r   <= SUM_W'(cfg_data) * SUM_W'(WINDOW_LEN);
    end
  end

  // convert the registered raw word to lux and the night flag
  lahs_lux_conv u_conv (
    .raw    (s1_raw_r),
    .thr100 (thr100_r),
    .res    (conv)
  );

  // read the evicted slot as the item enters stage two, write it on leaving
  assign win_ctl.rd_en = adv && s1_vld_r;
  assign win_ctl.wr_en = adv && s2_vld_r;

  lahs_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wr_lux  (s2_lux_r),
    .new_sum (win_sum),
    .avg_ok  (win_avg_ok),
    .full    (win_full)
  );

  // turn-off wins; turn-on only while the lamp is off
  assign turn_off = lamp_r && win_avg_ok && (win_sum > thrn_r);
  assign turn_on  = s2_night_r && !lamp_r;
  assign lamp_nxt = turn_off ? 1'b0 : (turn_on ? 1'b1 : lamp_r);

  lahs_avg_div #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_div (
    .sum (s3_sum_r),
    .avg (avg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      lamp_r    <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
      if (s2_vld_r) begin
        lamp_r <= lamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw_r     <= in_tdata;
      s2_lux_r     <= conv.lux;
      s2_night_r   <= conv.night;
      s3_lux_r     <= s2_lux_r;
      s3_sum_r     <= win_sum;
      s3_avg_ok_r  <= win_avg_ok;
      s3_lamp_r    <= lamp_nxt;
      s3_chg_r     <= turn_off || turn_on;
      out_lux_r    <= s3_lux_r;
      out_avg_r    <= s3_avg_ok_r ? avg : '0;
      out_avg_ok_r <= s3_avg_ok_r;
      out_lamp_r   <= s3_lamp_r;
      out_chg_r    <= s3_chg_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_chg_r, out_lamp_r, out_avg_ok_r, out_avg_r, out_lux_r};

  // no average is reported before the window has filled
  a_avg_zero_until_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_avg_ok_r) |-> (out_avg_r == '0))
    else $error("average reported before the window filled");

  // the lamp only switches off against a valid average
  a_off_needs_avg : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_chg_r && !s3_lamp_r) |-> s3_avg_ok_r)
    else $error("headlight switched off without a valid average");

  // once full, the window stays full until reset
  a_full_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    win_full |=> win_full)
    else $error("window-full flag dropped");

endmodule
